FILE: design/sync_pattern_remap_hamming_min_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync pattern distance core
// Shared property wrappers clocked on clk, one disabled by the active-low reset.
// ---------------------------------------------------------------------------
`ifndef SYNC_PATTERN_REMAP_HAMMING_MIN_CORE_MACROS_SVH
`define SYNC_PATTERN_REMAP_HAMMING_MIN_CORE_MACROS_SVH

// property checked only while out of reset
`define SPRHM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sprhm assertion failed");

// property checked at every edge, reset included
`define SPRHM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sprhm assertion failed (always)");

`endif

FILE: design/sprhm_pkg.sv
// ---------------------------------------------------------------------------
// sprhm_pkg
// Shared constants and types of the sync pattern distance core.
// ---------------------------------------------------------------------------
package sprhm_pkg;

  // window length limit, 1..32
  localparam int MAX_SYNC_DIBITS = 32;

  localparam int PAT_W      = 64;
  localparam int PAT_DIBITS = PAT_W / 2;
  localparam int IDX_W      = $clog2(PAT_DIBITS);
  localparam int POS_W      = 6;
  localparam int CNT_W      = 6;
  localparam int SYM_W      = 8;
  localparam int NUM_REMAPS = 5;
  localparam int NUM_COUNTS = 2 * NUM_REMAPS;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SYNC_DIBITS);

  // ASCII range of the decoded symbols
  localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CHAR_THREE = 8'h33;
  localparam logic [1:0]       DIBIT_MASK = 2'h3;

  // register indexes on the config port
  typedef enum logic {
    REG_PATTERN_NORMAL   = 1'b0,
    REG_PATTERN_INVERTED = 1'b1
  } reg_idx_t;

  // rotation 0->1->3->2->0 on the low two bits
  localparam logic [1:0] ROT_TABLE [0:3] = '{2'd1, 2'd3, 2'd0, 2'd2};

  typedef logic [CNT_W-1:0] cnt_t;
  typedef cnt_t             cnt_bank_t [NUM_COUNTS];
  typedef logic [NUM_COUNTS-1:0] miss_t;

endpackage

FILE: design/sprhm_match.sv
// ---------------------------------------------------------------------------
// sprhm_match
// Decodes one symbol, builds its five remaps and flags the mismatches
// against the expected normal and inverted dibits.
// ---------------------------------------------------------------------------
module sprhm_match
  import sprhm_pkg::*;
(
  input  logic [SYM_W-1:0] symbol_char,
  input  logic [1:0]       exp_normal,
  input  logic [1:0]       exp_inverted,
  output miss_t            miss
);

  logic [SYM_W-1:0] dec;
  logic [SYM_W-1:0] r_ident;
  logic [1:0]       r_inv;
  logic [1:0]       r_swap;
  logic [SYM_W-1:0] r_xor;
  logic [1:0]       r_rot;

  // ASCII '0'..'3' become 0..3, other bytes stay raw
  always_comb begin
    if (symbol_char >= CHAR_ZERO && symbol_char <= CHAR_THREE) begin
      dec = {{(SYM_W-2){1'b0}}, symbol_char[1:0]};
    end else begin
      dec = symbol_char;
    end
  end

  // five remaps
  always_comb begin
    r_ident = dec;
    unique case (dec)
      8'd0:    r_inv = 2'd2;
      8'd1:    r_inv = 2'd3;
      8'd2:    r_inv = 2'd0;
      default: r_inv = 2'd1;
    endcase
    r_swap = {dec[0], dec[1]};
    r_xor  = dec ^ {{(SYM_W-2){1'b0}}, DIBIT_MASK};
    r_rot  = ROT_TABLE[dec[1:0]];
  end

  // even bit: normal pattern, odd bit: inverted pattern
  always_comb begin
    miss[0] = r_ident != {{(SYM_W-2){1'b0}}, exp_normal};
    miss[1] = r_ident != {{(SYM_W-2){1'b0}}, exp_inverted};
    miss[2] = r_inv   != exp_normal;
    miss[3] = r_inv   != exp_inverted;
    miss[4] = r_swap  != exp_normal;
    miss[5] = r_swap  != exp_inverted;
    miss[6] = r_xor   != {{(SYM_W-2){1'b0}}, exp_normal};
    miss[7] = r_xor   != {{(SYM_W-2){1'b0}}, exp_inverted};
    miss[8] = r_rot   != exp_normal;
    miss[9] = r_rot   != exp_inverted;
  end

endmodule

FILE: design/sprhm_min.sv
// ---------------------------------------------------------------------------
// sprhm_min
// Four-level compare tree picking the smallest of the ten counters.
// ---------------------------------------------------------------------------
module sprhm_min
  import sprhm_pkg::*;
(
  input  cnt_bank_t counts,
  output cnt_t      min_count
);

  cnt_t l1 [5];
  cnt_t l2 [3];
  cnt_t l3 [2];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      l1[i] = (counts[2*i+1] < counts[2*i]) ? counts[2*i+1] : counts[2*i];
    end
    l2[0] = (l1[1] < l1[0]) ? l1[1] : l1[0];
    l2[1] = (l1[3] < l1[2]) ? l1[3] : l1[2];
    l2[2] = l1[4];
    l3[0] = (l2[1] < l2[0]) ? l2[1] : l2[0];
    l3[1] = l2[2];
    min_count = (l3[1] < l3[0]) ? l3[1] : l3[0];
  end

endmodule

FILE: design/sync_pattern_remap_hamming_min_core.sv
// ---------------------------------------------------------------------------
// sync_pattern_remap_hamming_min_core
// Hamming distance of a received symbol window against a sync pattern.
// ---------------------------------------------------------------------------
// Takes one symbol byte per cycle while in_tready is high and keeps ten
// mismatch counters (five symbol remaps against the normal and the
// inverted pattern). The word with tlast set produces one result, the
// smallest counter including that word, and starts a new window. A last
// word waits in the input register until the output slot is free, then
// goes through the counter update and compare tree into the output
// register. Symbols past MAX_SYNC_DIBITS are not counted. Patterns must be
// written through cfg_* while the core is idle; the core does not check it.
module sync_pattern_remap_hamming_min_core
  import sprhm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // config write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [PAT_W-1:0] cfg_data,
  // symbol input
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] symbol_char
  input  logic             in_tlast,   // last_symbol
  // result output
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata   // [5:0] min_distance, [7:6] zero
);

  logic [PAT_W-1:0] pat_normal_r;
  logic [PAT_W-1:0] pat_inverted_r;

  logic             s0_valid_r;
  logic [SYM_W-1:0] s0_char_r;
  logic             s0_last_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  cnt_bank_t        cnt_r, cnt_nxt, cnt_upd;

  logic             out_valid_r;
  cnt_t             out_min_r;

  logic             s0_adv;
  logic             in_take;
  logic             in_window;
  logic [IDX_W-1:0] idx;
  miss_t            miss;
  cnt_t             min_count;

  // config writes always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_normal_r   <= '0;
      pat_inverted_r <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PATTERN_NORMAL:   pat_normal_r   <= cfg_data;
        REG_PATTERN_INVERTED: pat_inverted_r <= cfg_data;
        default:              ;
      endcase
    end
  end

  // a last word may only retire when the output slot frees up
  assign s0_adv    = s0_valid_r && (!s0_last_r || !out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || s0_adv;
  assign in_take   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_char_r <= in_tdata;
      s0_last_r <= in_tlast;
    end
  end

  // expected dibits at the current position
  assign in_window = pos_r < POS_LIMIT;
  assign idx       = pos_r[IDX_W-1:0];

  sprhm_match u_match (
    .symbol_char  (s0_char_r),
    .exp_normal   (pat_normal_r[{idx, 1'b0} +: 2]),
    .exp_inverted (pat_inverted_r[{idx, 1'b0} +: 2]),
    .miss         (miss)
  );

  // counter bank update, cleared after the last word
  always_comb begin
    for (int i = 0; i < NUM_COUNTS; i++) begin
      cnt_upd[i] = cnt_r[i] + {{(CNT_W-1){1'b0}}, (in_window && miss[i])};
    end
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (s0_adv) begin
      if (s0_last_r) begin
        cnt_nxt = '{default: '0};
        pos_nxt = '0;
      end else begin
        cnt_nxt = cnt_upd;
        pos_nxt = in_window ? pos_r + POS_W'(1) : pos_r;
      end
    end
  end

  sprhm_min u_min (
    .counts    (cnt_upd),
    .min_count (min_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '{default: '0};
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv && s0_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv && s0_last_r) begin
      out_min_r <= min_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8-CNT_W){1'b0}}, out_min_r};

endmodule

FILE: design/sprhm_checker.sv
// ---------------------------------------------------------------------------
// sprhm_checker
// Port-level checks of the sync pattern distance core, bound to the top.
// ---------------------------------------------------------------------------
`include "sync_pattern_remap_hamming_min_core_macros.svh"

module sprhm_checker
  import sprhm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result word holds
  `SPRHM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // distance never exceeds the window length, upper bits stay zero
  `SPRHM_ASSERT(a_out_range, out_tvalid |-> out_tdata[7:6] == 2'b00 && out_tdata[5:0] <= 6'd32)

  // a rising result must be preceded by an accepted last word
  `SPRHM_ASSERT(a_out_cause, $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))

  // reset leaves no result pending
  `SPRHM_ASSERT_ALWAYS(a_out_reset, !rst_n |=> !out_tvalid)

  // config channel never stalls
  `SPRHM_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)

endmodule

bind sync_pattern_remap_hamming_min_core sprhm_checker u_sprhm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
